FILE: rtl/hcbd_pkg.sv
// ----------------------------------------------------------------------------
// hcbd_pkg
// shared types, constants and helpers of the chunked body decoder
// ----------------------------------------------------------------------------
`default_nettype none

package hcbd_pkg;

    // line length limit, crlf included in the count
    localparam int LINE_CAP = 1024;
    localparam int LINE_W   = $clog2(LINE_CAP);
    localparam int TRL_W    = 17;
    localparam int ACC_W    = 33;

    localparam logic [31:0]      RST_MAX_BODY    = 32'd8388608;
    localparam logic [15:0]      RST_MAX_TRAILER = 16'd32768;
    localparam logic [ACC_W-1:0] ACC_SAT         = 33'h1_0000_0000;
    localparam logic [LINE_W-1:0] LINE_LIMIT     = LINE_W'(LINE_CAP - 1);

    // configuration register indexes
    localparam int          CFG_IDX_W       = 2;
    localparam logic [1:0]  CFG_MAX_BODY    = 2'd0;
    localparam logic [1:0]  CFG_MAX_TRAILER = 2'd1;

    // phases
    localparam logic [2:0] PH_SIZE    = 3'd0;
    localparam logic [2:0] PH_DATA    = 3'd1;
    localparam logic [2:0] PH_DATA_CR = 3'd2;
    localparam logic [2:0] PH_DATA_LF = 3'd3;
    localparam logic [2:0] PH_TRAILER = 3'd4;
    localparam logic [2:0] PH_DONE    = 3'd5;
    localparam logic [2:0] PH_FAIL    = 3'd6;

    // size line sub states
    localparam logic [2:0] SS_FIRST  = 3'd0;
    localparam logic [2:0] SS_ZERO   = 3'd1;
    localparam logic [2:0] SS_X      = 3'd2;
    localparam logic [2:0] SS_DIGITS = 3'd3;
    localparam logic [2:0] SS_CR     = 3'd4;
    localparam logic [2:0] SS_EXT    = 3'd5;

    // failure causes
    localparam logic [2:0] CAUSE_NONE     = 3'd0;
    localparam logic [2:0] CAUSE_BAD_LINE = 3'd1;
    localparam logic [2:0] CAUSE_OVERSIZE = 3'd2;
    localparam logic [2:0] CAUSE_LONG     = 3'd3;
    localparam logic [2:0] CAUSE_NO_CRLF  = 3'd4;
    localparam logic [2:0] CAUSE_TRAILER  = 3'd5;
    localparam logic [2:0] CAUSE_CLOSE    = 3'd6;

    // characters
    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_CR   = 8'h0d;
    localparam logic [7:0] CH_LF   = 8'h0a;
    localparam logic [7:0] CH_SEMI = 8'h3b;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_X_LO = 8'h78;
    localparam logic [7:0] CH_X_UP = 8'h58;

    typedef struct packed {
        logic       kind;
        logic [7:0] stream_byte;
    } t_item;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       payload_valid;
        logic       finished;
        logic       failed;
        logic [2:0] fail_cause;
    } t_result;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    function automatic t_hex hex_value(input logic [7:0] b);
        t_hex h;
        h.ok  = 1'b1;
        h.val = 4'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            h.val = 4'(b - 8'h30);
        end else if (b >= 8'h61 && b <= 8'h66) begin
            h.val = 4'(b - 8'h57);
        end else if (b >= 8'h41 && b <= 8'h46) begin
            h.val = 4'(b - 8'h37);
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/hcbd_in_if.sv
// ----------------------------------------------------------------------------
// hcbd_in_if
// stream event channel into the chunked body decoder
// ----------------------------------------------------------------------------
`default_nettype none

interface hcbd_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] stream_byte;

    modport source (output valid, output kind, output stream_byte, input ready);
    modport sink   (input valid, input kind, input stream_byte, output ready);
endinterface

`default_nettype wire

FILE: rtl/hcbd_out_if.sv
// ----------------------------------------------------------------------------
// hcbd_out_if
// result channel out of the chunked body decoder
// ----------------------------------------------------------------------------
`default_nettype none

interface hcbd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic       payload_valid;
    logic       finished;
    logic       failed;
    logic [2:0] fail_cause;

    modport source (output valid, output payload_byte, output payload_valid,
                    output finished, output failed, output fail_cause, input ready);
    modport sink   (input valid, input payload_byte, input payload_valid,
                    input finished, input failed, input fail_cause, output ready);
endinterface

`default_nettype wire

FILE: rtl/hcbd_in_reg.sv
// ----------------------------------------------------------------------------
// hcbd_in_reg
// input register stage in front of the decode engine
// ----------------------------------------------------------------------------
`default_nettype none

module hcbd_in_reg
    import hcbd_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    input  wire t_item  i_item,
    input  wire         i_advance,
    output logic        o_ready,
    output logic        o_valid,
    output t_item       o_item
);

    logic  r_valid;
    t_item r_item;

    // stage refills when empty or when its item moves on
    assign o_ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

FILE: rtl/hcbd_engine.sv
// ----------------------------------------------------------------------------
// hcbd_engine
// framing state and one-byte decode step of the chunked body decoder
// ----------------------------------------------------------------------------
`default_nettype none

module hcbd_engine
    import hcbd_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_step,
    input  wire t_item   i_item,
    input  wire   [31:0] i_max_body,
    input  wire   [15:0] i_max_trailer,
    output t_result      o_res
);

    logic [2:0]        r_phase,  n_phase;
    logic [2:0]        r_sub,    n_sub;
    logic [LINE_W-1:0] r_line,   n_line;
    logic [ACC_W-1:0]  r_acc,    n_acc;
    logic              r_cr,     n_cr;
    logic [31:0]       r_left,   n_left;
    logic [31:0]       r_total,  n_total;
    logic [TRL_W-1:0]  r_trl,    n_trl;
    logic [2:0]        r_err,    n_err;

    logic [7:0]        b;
    t_hex              hx;
    logic [LINE_W-1:0] line_inc;
    logic [ACC_W-1:0]  acc_next;
    logic [ACC_W:0]    size_sum;
    logic              too_big;
    logic [TRL_W-1:0]  trl_sum;
    logic              do_accept;
    logic              pvalid;

    assign b        = i_item.stream_byte;
    assign hx       = hex_value(b);
    assign line_inc = r_line + 1'b1;

    // accumulator saturates at 2^32: anything at or above 2^28 pins there
    assign acc_next = (|r_acc[ACC_W-1:28]) ? ACC_SAT : {1'b0, r_acc[27:0], hx.val};

    // total is never negative, so one sum covers both limit checks
    assign size_sum = {2'b00, r_total} + {1'b0, r_acc};
    assign too_big  = size_sum > {2'b00, i_max_body};
    assign trl_sum  = r_trl + TRL_W'(line_inc);

    always_comb begin
        n_phase   = r_phase;
        n_sub     = r_sub;
        n_line    = r_line;
        n_acc     = r_acc;
        n_cr      = r_cr;
        n_left    = r_left;
        n_total   = r_total;
        n_trl     = r_trl;
        n_err     = r_err;
        pvalid    = 1'b0;
        do_accept = 1'b0;

        if (r_phase != PH_DONE && r_phase != PH_FAIL) begin
            if (i_item.kind) begin
                n_phase = PH_FAIL;
                n_err   = CAUSE_CLOSE;
            end else begin
                unique case (r_phase)
                    PH_SIZE: begin
                        if (b == CH_NUL) begin
                            n_phase = PH_FAIL;
                            n_err   = CAUSE_BAD_LINE;
                        end else begin
                            n_line = line_inc;
                            unique case (r_sub)
                                SS_FIRST, SS_X: begin
                                    if (!hx.ok) begin
                                        n_phase = PH_FAIL;
                                        n_err   = CAUSE_BAD_LINE;
                                    end else begin
                                        n_acc = ACC_W'(hx.val);
                                        n_sub = (r_sub == SS_FIRST && b == CH_ZERO) ?
                                                SS_ZERO : SS_DIGITS;
                                    end
                                end
                                SS_ZERO, SS_DIGITS: begin
                                    if (r_sub == SS_ZERO && (b == CH_X_LO || b == CH_X_UP)) begin
                                        n_sub = SS_X;
                                    end else if (hx.ok) begin
                                        n_acc = acc_next;
                                        n_sub = SS_DIGITS;
                                    end else if (b == CH_SEMI) begin
                                        if (too_big) begin
                                            n_phase = PH_FAIL;
                                            n_err   = CAUSE_OVERSIZE;
                                        end else begin
                                            n_sub = SS_EXT;
                                            n_cr  = 1'b0;
                                        end
                                    end else if (b == CH_CR) begin
                                        n_sub = SS_CR;
                                    end else begin
                                        n_phase = PH_FAIL;
                                        n_err   = CAUSE_BAD_LINE;
                                    end
                                end
                                SS_CR: begin
                                    if (b != CH_LF) begin
                                        n_phase = PH_FAIL;
                                        n_err   = CAUSE_BAD_LINE;
                                    end else if (too_big) begin
                                        n_phase = PH_FAIL;
                                        n_err   = CAUSE_OVERSIZE;
                                    end else begin
                                        do_accept = 1'b1;
                                    end
                                end
                                default: begin
                                    // extension text, skipped up to crlf
                                    if (r_cr && b == CH_LF) begin
                                        do_accept = 1'b1;
                                    end else begin
                                        n_cr = (b == CH_CR);
                                    end
                                end
                            endcase
                            if (do_accept) begin
                                n_total = r_total + r_acc[31:0];
                                if (r_acc[31:0] == 32'd0) begin
                                    n_phase = PH_TRAILER;
                                    n_line  = '0;
                                    n_cr    = 1'b0;
                                    n_trl   = '0;
                                end else begin
                                    n_phase = PH_DATA;
                                    n_left  = r_acc[31:0];
                                end
                            end else if (n_phase == PH_SIZE && line_inc >= LINE_LIMIT) begin
                                n_phase = PH_FAIL;
                                n_err   = CAUSE_LONG;
                            end
                        end
                    end
                    PH_DATA: begin
                        pvalid = 1'b1;
                        n_left = r_left - 32'd1;
                        if (r_left == 32'd1) begin
                            n_phase = PH_DATA_CR;
                        end
                    end
                    PH_DATA_CR: begin
                        if (b == CH_CR) begin
                            n_phase = PH_DATA_LF;
                        end else begin
                            n_phase = PH_FAIL;
                            n_err   = CAUSE_NO_CRLF;
                        end
                    end
                    PH_DATA_LF: begin
                        if (b == CH_LF) begin
                            n_phase = PH_SIZE;
                            n_sub   = SS_FIRST;
                            n_line  = '0;
                            n_acc   = '0;
                            n_cr    = 1'b0;
                        end else begin
                            n_phase = PH_FAIL;
                            n_err   = CAUSE_NO_CRLF;
                        end
                    end
                    PH_TRAILER: begin
                        if (b == CH_NUL) begin
                            n_phase = PH_FAIL;
                            n_err   = CAUSE_BAD_LINE;
                        end else begin
                            n_line = line_inc;
                            if (r_cr && b == CH_LF) begin
                                n_trl = trl_sum;
                                if (trl_sum > TRL_W'(i_max_trailer)) begin
                                    n_phase = PH_FAIL;
                                    n_err   = CAUSE_TRAILER;
                                end else if (line_inc == LINE_W'(2)) begin
                                    n_phase = PH_DONE;
                                end else begin
                                    n_line = '0;
                                    n_cr   = 1'b0;
                                end
                            end else begin
                                n_cr = (b == CH_CR);
                                if (line_inc >= LINE_LIMIT) begin
                                    n_phase = PH_FAIL;
                                    n_err   = CAUSE_LONG;
                                end
                            end
                        end
                    end
                    default: begin
                        n_phase = r_phase;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SIZE;
            r_sub   <= SS_FIRST;
            r_line  <= '0;
            r_acc   <= '0;
            r_cr    <= 1'b0;
            r_left  <= '0;
            r_total <= '0;
            r_trl   <= '0;
            r_err   <= CAUSE_NONE;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_sub   <= n_sub;
            r_line  <= n_line;
            r_acc   <= n_acc;
            r_cr    <= n_cr;
            r_left  <= n_left;
            r_total <= n_total;
            r_trl   <= n_trl;
            r_err   <= n_err;
        end
    end

    always_comb begin
        o_res.payload_byte  = pvalid ? b : 8'd0;
        o_res.payload_valid = pvalid;
        o_res.finished      = (n_phase == PH_DONE);
        o_res.failed        = (n_phase == PH_FAIL);
        o_res.fail_cause    = n_err;
    end

`ifndef ASSERT_OFF
    a_fail_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_FAIL |=> r_phase == PH_FAIL)
        else $error("failure state left without reset");
    a_cause_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_FAIL) == (r_err != CAUSE_NONE))
        else $error("fail cause disagrees with phase");
    a_data_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_DATA |-> r_left != 32'd0)
        else $error("data phase with no bytes left");
    a_acc_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_acc <= ACC_SAT)
        else $error("size accumulator above saturation value");
`endif

endmodule

`default_nettype wire

FILE: rtl/http_chunked_body_decoder.sv
// ----------------------------------------------------------------------------
// http_chunked_body_decoder
// decodes an http/1.1 chunked message body into its payload bytes
// ----------------------------------------------------------------------------
// usage
//   i_in carries one event per transaction: kind 0 with a body byte, or
//   kind 1 when the peer closed the stream. o_out returns exactly one result
//   per input transaction: the payload byte with payload_valid when the byte
//   was chunk data, plus the finished, failed and fail_cause flags.
//   limits are written on the i_cfg_* port (index 0 max body bytes, index 1
//   max trailer bytes) while no transaction is in flight.
// timing
//   one transaction per clock sustained while o_out.ready stays high. a result
//   passes two registers on its way to o_out: the input register captures the
//   event, then the decode step result moves into the output register. the decode
//   step is a single 34-bit add and compare for the size limit per cycle.
// reset
//   synchronous, active low: framing state clears to the first size line,
//   limits return to 8 MiB and 32 KiB, both stages empty.
// stall
//   while o_out.ready is low the result holds, the input register holds
//   one more item, then i_in.ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module http_chunked_body_decoder
    import hcbd_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    hcbd_in_if.sink              i_in,
    hcbd_out_if.source           o_out,
    input  wire                  i_cfg_we,
    input  wire [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire [31:0]           i_cfg_wdata
);

    // limit registers
    logic [31:0] r_max_body;
    logic [15:0] r_max_trailer;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_body    <= RST_MAX_BODY;
            r_max_trailer <= RST_MAX_TRAILER;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_MAX_BODY) begin
                r_max_body <= i_cfg_wdata;
            end else if (i_cfg_idx == CFG_MAX_TRAILER) begin
                r_max_trailer <= i_cfg_wdata[15:0];
            end
        end
    end

    // output register and the stage advance that drives the whole pipe
    logic    r_out_valid;
    t_result r_out_res;
    logic    advance;
    logic    step;
    logic    st_valid;
    t_item   st_item;
    t_item   in_item;
    t_result res;

    assign advance = !r_out_valid || o_out.ready;
    assign step    = st_valid && advance;

    assign in_item.kind        = i_in.kind;
    assign in_item.stream_byte = i_in.stream_byte;

    hcbd_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in.valid),
        .i_item    (in_item),
        .i_advance (advance),
        .o_ready   (i_in.ready),
        .o_valid   (st_valid),
        .o_item    (st_item)
    );

    // state update happens only when the result can be registered
    hcbd_engine u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_item        (st_item),
        .i_max_body    (r_max_body),
        .i_max_trailer (r_max_trailer),
        .o_res         (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= st_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_res <= res;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.payload_byte  = r_out_res.payload_byte;
    assign o_out.payload_valid = r_out_res.payload_valid;
    assign o_out.finished      = r_out_res.finished;
    assign o_out.failed        = r_out_res.failed;
    assign o_out.fail_cause    = r_out_res.fail_cause;

endmodule

`default_nettype wire
